[rtl/knt_pkg.sv]
// shared types, character codes and lookup functions of the keyword/number tokenizer
package knt_pkg;

   // token kinds on the result channel
   typedef enum logic [3:0] {
      KIND_IDENT   = 4'd0,
      KIND_NUMBER  = 4'd1,
      KIND_IF      = 4'd2,
      KIND_ELSE    = 4'd3,
      KIND_INT     = 4'd4,
      KIND_PLUS    = 4'd5,
      KIND_MINUS   = 4'd6,
      KIND_MUL     = 4'd7,
      KIND_LBRACE  = 4'd8,
      KIND_RBRACE  = 4'd9,
      KIND_EQ      = 4'd10,
      KIND_SEMI    = 4'd11,
      KIND_UNKNOWN = 4'd12,
      KIND_EOF     = 4'd13
   } kind_type;

   // scanner mode between characters
   typedef enum logic [1:0] {
      MODE_START   = 2'd0,
      MODE_WORD    = 2'd1,
      MODE_NUMBER  = 2'd2,
      MODE_COMMENT = 2'd3
   } mode_type;

   // keywords tracked while a word is collected
   typedef enum logic [1:0] {
      KW_IF   = 2'd0,
      KW_ELSE = 2'd1,
      KW_INT  = 2'd2
   } kw_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_EVAL  = 3'd1,
      ST_FLUSH = 3'd2,
      ST_KW    = 3'd3,
      ST_TAIL  = 3'd4
   } state_type;

   // source of the beat loaded into the output register
   typedef enum logic [1:0] {
      EMIT_NONE = 2'd0,
      EMIT_TEXT = 2'd1,
      EMIT_KW   = 2'd2,
      EMIT_TAIL = 2'd3
   } emit_type;

   // commands from controller to datapath
   typedef struct packed {
      logic     latch;
      logic     rd_start;
      logic     rd_next;
      logic     commit;
      emit_type emit;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic need_flush;
      logic is_kw;
      logic has_tail;
      logic flush_final;
      logic out_free;
   } stat_type;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // single-character token kinds, unknown for anything unlisted
   function automatic kind_type char_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_MINUS;
         CH_STAR:   k = KIND_MUL;
         CH_LBRACE: k = KIND_LBRACE;
         CH_RBRACE: k = KIND_RBRACE;
         CH_EQ:     k = KIND_EQ;
         CH_SEMI:   k = KIND_SEMI;
         default:   k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   // keyword text by position
   function automatic logic [7:0] kw_byte(input kw_type kw, input logic [1:0] pos);
      logic [7:0] b;
      case (kw)
         KW_IF: begin
            case (pos)
               2'd0:    b = 8'h69; // i
               2'd1:    b = 8'h66; // f
               default: b = 8'h00;
            endcase
         end
         KW_ELSE: begin
            case (pos)
               2'd0:    b = 8'h65; // e
               2'd1:    b = 8'h6C; // l
               2'd2:    b = 8'h73; // s
               default: b = 8'h65; // e
            endcase
         end
         KW_INT: begin
            case (pos)
               2'd0:    b = 8'h69; // i
               2'd1:    b = 8'h6E; // n
               2'd2:    b = 8'h74; // t
               default: b = 8'h00;
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[rtl/knt_ifs.sv]
// valid/ready channel interfaces for source characters and tokens

interface knt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_input;

   modport source (output valid, output char_byte, output end_of_input, input ready);
   modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface knt_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] token_kind;
   logic [7:0] text_char;
   logic [4:0] char_index;
   logic       has_text;
   logic       token_end;
   logic       word_truncated;
   logic       last;

   modport source (output valid, output token_kind, output text_char, output char_index,
                   output has_text, output token_end, output word_truncated, output last,
                   input ready);
   modport sink   (input valid, input token_kind, input text_char, input char_index,
                   input has_text, input token_end, input word_truncated, input last,
                   output ready);
endinterface

[rtl/knt_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module knt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/knt_ctrl.sv]
// sequencing state machine of the tokenizer
module knt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  knt_pkg::stat_type stat,
   output knt_pkg::cmd_type  cmd
);

   knt_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= knt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.latch    = 1'b0;
      cmd.rd_start = 1'b0;
      cmd.rd_next  = 1'b0;
      cmd.commit   = 1'b0;
      cmd.emit     = knt_pkg::EMIT_NONE;
      case (state_ff)
         knt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = knt_pkg::ST_EVAL;
            end
         end
         knt_pkg::ST_EVAL: begin
            if (stat.need_flush) begin
               if (stat.is_kw) begin
                  state_in = knt_pkg::ST_KW;
               end else begin
                  cmd.rd_start = 1'b1;
                  state_in     = knt_pkg::ST_FLUSH;
               end
            end else if (stat.has_tail) begin
               state_in = knt_pkg::ST_TAIL;
            end else begin
               cmd.commit = 1'b1;
               state_in   = knt_pkg::ST_IDLE;
            end
         end
         knt_pkg::ST_FLUSH: begin
            if (stat.out_free) begin
               cmd.emit = knt_pkg::EMIT_TEXT;
               if (!stat.flush_final) begin
                  cmd.rd_next = 1'b1;
               end else if (stat.has_tail) begin
                  state_in = knt_pkg::ST_TAIL;
               end else begin
                  cmd.commit = 1'b1;
                  state_in   = knt_pkg::ST_IDLE;
               end
            end
         end
         knt_pkg::ST_KW: begin
            if (stat.out_free) begin
               cmd.emit = knt_pkg::EMIT_KW;
               if (stat.has_tail) begin
                  state_in = knt_pkg::ST_TAIL;
               end else begin
                  cmd.commit = 1'b1;
                  state_in   = knt_pkg::ST_IDLE;
               end
            end
         end
         knt_pkg::ST_TAIL: begin
            if (stat.out_free) begin
               cmd.emit   = knt_pkg::EMIT_TAIL;
               cmd.commit = 1'b1;
               state_in   = knt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = knt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/knt_dp.sv]
// datapath: character classing, word buffer, keyword tracking and output register
module knt_dp #(
   parameter int MAX_WORD = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  knt_pkg::cmd_type  cmd,
   output knt_pkg::stat_type stat,
   input  logic [7:0]        req_char_byte,
   input  logic              req_end_of_input,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_token_kind,
   output logic [7:0]        rsp_text_char,
   output logic [4:0]        rsp_char_index,
   output logic              rsp_has_text,
   output logic              rsp_token_end,
   output logic              rsp_word_truncated,
   output logic              rsp_last
);

   localparam int AW = $clog2(MAX_WORD);
   localparam int LW = $clog2(MAX_WORD + 1);

   // latched input beat
   logic [7:0] char_ff;
   logic       eoi_ff;

   // scanner state
   knt_pkg::mode_type mode_ff, mode_in;
   logic [LW-1:0]     len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic              m_if_ff, m_if_in;
   logic              m_else_ff, m_else_in;
   logic              m_int_ff, m_int_in;
   logic [AW-1:0]     idx_ff, idx_in;

   // output register
   logic       valid_ff, valid_in;
   logic [3:0] kind_ff, kind_in;
   logic [7:0] text_ff, text_in;
   logic [4:0] cidx_ff, cidx_in;
   logic       has_ff, has_in;
   logic       end_ff, end_in;
   logic       trunc_ff, trunc_in;
   logic       last_ff, last_in;

   // word buffer ports
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // character classes
   logic is_wordc, is_dig, is_blank, cont_word, cont_num;
   logic need_flush, do_start, do_append, has_tail;
   logic hit_if, hit_else, hit_int, is_kw, flush_final;
   knt_pkg::kind_type kw_kind, tail_kind;

   knt_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WORD)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (char_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // decode of the latched character against the current mode
   always_comb begin
      is_dig    = knt_pkg::is_digit(char_ff);
      is_wordc  = knt_pkg::is_letter(char_ff) || is_dig || (char_ff == knt_pkg::CH_UNDER);
      is_blank  = (char_ff == knt_pkg::CH_SPACE) || (char_ff == knt_pkg::CH_LF);
      cont_word = (mode_ff == knt_pkg::MODE_WORD) && is_wordc;
      cont_num  = (mode_ff == knt_pkg::MODE_NUMBER) && is_dig;
      need_flush = ((mode_ff == knt_pkg::MODE_WORD) || (mode_ff == knt_pkg::MODE_NUMBER)) &&
                   (eoi_ff || !(cont_word || cont_num));
      do_append = !eoi_ff && (cont_word || cont_num);
      do_start  = !eoi_ff && ((mode_ff == knt_pkg::MODE_START) || need_flush ||
                  ((mode_ff == knt_pkg::MODE_COMMENT) &&
                   ((char_ff == knt_pkg::CH_LF) || (char_ff == knt_pkg::CH_CR))));
      has_tail  = eoi_ff || (do_start && !is_blank && !is_wordc &&
                  (char_ff != knt_pkg::CH_HASH));
      hit_if    = m_if_ff && (len_ff == LW'(2));
      hit_else  = m_else_ff && (len_ff == LW'(4));
      hit_int   = m_int_ff && (len_ff == LW'(3));
      is_kw     = (mode_ff == knt_pkg::MODE_WORD) && !ovf_ff && (hit_if || hit_else || hit_int);
      flush_final = (LW'(idx_ff) + LW'(1)) == len_ff;
      if (hit_if) begin
         kw_kind = knt_pkg::KIND_IF;
      end else if (hit_else) begin
         kw_kind = knt_pkg::KIND_ELSE;
      end else begin
         kw_kind = knt_pkg::KIND_INT;
      end
      tail_kind = eoi_ff ? knt_pkg::KIND_EOF : knt_pkg::char_kind(char_ff);
   end

   assign stat.need_flush  = need_flush;
   assign stat.is_kw       = is_kw;
   assign stat.has_tail    = has_tail;
   assign stat.flush_final = flush_final;
   assign stat.out_free    = !valid_ff || rsp_ready;

   // buffer read sequencing for the flush
   always_comb begin
      rd_en   = cmd.rd_start || cmd.rd_next;
      rd_addr = cmd.rd_next ? (idx_ff + AW'(1)) : '0;
      idx_in  = idx_ff;
      if (cmd.rd_start) begin
         idx_in = '0;
      end else if (cmd.rd_next) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   // scanner state update at the end of each input beat
   always_comb begin
      mode_in   = mode_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      m_if_in   = m_if_ff;
      m_else_in = m_else_ff;
      m_int_in  = m_int_ff;
      wr_en     = 1'b0;
      wr_addr   = len_ff[AW-1:0];
      if (cmd.commit) begin
         if (eoi_ff) begin
            mode_in = knt_pkg::MODE_START;
         end else if (do_append) begin
            if (len_ff < LW'(MAX_WORD)) begin
               wr_en     = 1'b1;
               len_in    = len_ff + LW'(1);
               m_if_in   = m_if_ff && (len_ff < LW'(2)) &&
                           (char_ff == knt_pkg::kw_byte(knt_pkg::KW_IF, len_ff[1:0]));
               m_else_in = m_else_ff && (len_ff < LW'(4)) &&
                           (char_ff == knt_pkg::kw_byte(knt_pkg::KW_ELSE, len_ff[1:0]));
               m_int_in  = m_int_ff && (len_ff < LW'(3)) &&
                           (char_ff == knt_pkg::kw_byte(knt_pkg::KW_INT, len_ff[1:0]));
            end else begin
               ovf_in = 1'b1;
            end
         end else if (do_start) begin
            if (is_wordc) begin
               mode_in   = is_dig ? knt_pkg::MODE_NUMBER : knt_pkg::MODE_WORD;
               wr_en     = 1'b1;
               wr_addr   = '0;
               len_in    = LW'(1);
               ovf_in    = 1'b0;
               m_if_in   = char_ff == knt_pkg::kw_byte(knt_pkg::KW_IF, 2'd0);
               m_else_in = char_ff == knt_pkg::kw_byte(knt_pkg::KW_ELSE, 2'd0);
               m_int_in  = char_ff == knt_pkg::kw_byte(knt_pkg::KW_INT, 2'd0);
            end else if (char_ff == knt_pkg::CH_HASH) begin
               mode_in = knt_pkg::MODE_COMMENT;
            end else begin
               mode_in = knt_pkg::MODE_START;
            end
         end
      end
   end

   // output register load
   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      text_in  = text_ff;
      cidx_in  = cidx_ff;
      has_in   = has_ff;
      end_in   = end_ff;
      trunc_in = trunc_ff;
      last_in  = last_ff;
      case (cmd.emit)
         knt_pkg::EMIT_TEXT: begin
            valid_in = 1'b1;
            kind_in  = (mode_ff == knt_pkg::MODE_NUMBER) ? knt_pkg::KIND_NUMBER
                                                         : knt_pkg::KIND_IDENT;
            text_in  = rd_data;
            cidx_in  = 5'(idx_ff);
            has_in   = 1'b1;
            end_in   = flush_final;
            trunc_in = ovf_ff;
            last_in  = flush_final && !has_tail;
         end
         knt_pkg::EMIT_KW: begin
            valid_in = 1'b1;
            kind_in  = kw_kind;
            text_in  = '0;
            cidx_in  = '0;
            has_in   = 1'b0;
            end_in   = 1'b1;
            trunc_in = 1'b0;
            last_in  = !has_tail;
         end
         knt_pkg::EMIT_TAIL: begin
            valid_in = 1'b1;
            kind_in  = tail_kind;
            has_in   = (tail_kind == knt_pkg::KIND_UNKNOWN);
            text_in  = (tail_kind == knt_pkg::KIND_UNKNOWN) ? char_ff : 8'h00;
            cidx_in  = '0;
            end_in   = 1'b1;
            trunc_in = 1'b0;
            last_in  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= knt_pkg::MODE_START;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         char_ff <= req_char_byte;
         eoi_ff  <= req_end_of_input;
      end
      m_if_ff   <= m_if_in;
      m_else_ff <= m_else_in;
      m_int_ff  <= m_int_in;
      idx_ff    <= idx_in;
      kind_ff   <= kind_in;
      text_ff   <= text_in;
      cidx_ff   <= cidx_in;
      has_ff    <= has_in;
      end_ff    <= end_in;
      trunc_ff  <= trunc_in;
      last_ff   <= last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_token_kind     = kind_ff;
   assign rsp_text_char      = text_ff;
   assign rsp_char_index     = cidx_ff;
   assign rsp_has_text       = has_ff;
   assign rsp_token_end      = end_ff;
   assign rsp_word_truncated = trunc_ff;
   assign rsp_last           = last_ff;

endmodule

[rtl/keyword_number_tokenizer_unit.sv]
// top level of the streaming keyword/number tokenizer
//
// Takes one source byte (or an end marker) per request beat and returns tokens as
// response beats; identifiers and numbers come out one text character per beat with
// token_end on the final one, and last marks the final beat caused by a request.
// One request is handled at a time: a byte that only extends a word, a comment or
// whitespace is accepted, then evaluated and updated. A byte that ends a word also
// flushes its buffered characters, reading the word buffer ram once per cycle at
// its single read port while the output register is free; each character leaves
// as its own beat. A keyword leaves as a single beat in place of its text, and a
// single-character token or eof that follows leaves as one more beat. Response
// stalls hold the sequencer until the output register is free. A result waiting
// in the output register does not stop the next request from being accepted. Words
// longer than MAX_WORD keep their first MAX_WORD characters and are flagged truncated.
module keyword_number_tokenizer_unit #(
   parameter int MAX_WORD = 32
) (
   input logic        clock,
   input logic        reset,
   knt_req_if.sink    req_chan,
   knt_rsp_if.source  rsp_chan
);

   knt_pkg::cmd_type  cmd;
   knt_pkg::stat_type stat;

   // sequencer
   knt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   knt_dp #(
      .MAX_WORD (MAX_WORD)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_char_byte      (req_chan.char_byte),
      .req_end_of_input   (req_chan.end_of_input),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_token_kind     (rsp_chan.token_kind),
      .rsp_text_char      (rsp_chan.text_char),
      .rsp_char_index     (rsp_chan.char_index),
      .rsp_has_text       (rsp_chan.has_text),
      .rsp_token_end      (rsp_chan.token_end),
      .rsp_word_truncated (rsp_chan.word_truncated),
      .rsp_last           (rsp_chan.last)
   );

endmodule

[test/tb.sv]
// testbench for keyword_number_tokenizer_unit: directed and random text against a lexer model
`timescale 1ns / 100ps

module tb;

   localparam int MAX_WORD     = 32;
   localparam int RANDOM_CHARS = 380;
   localparam int CALM_CHARS   = 60;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 50;
   localparam int PRINT_LIMIT  = 60;

   localparam logic [7:0] LOW_A   = "a";
   localparam logic [7:0] UP_A    = "A";
   localparam logic [7:0] DIGIT_0 = "0";

   // one result beat
   typedef struct packed {
      knt_pkg::kind_type kind;
      logic [7:0]        text;
      logic [4:0]        pos;
      logic              has_text;
      logic              tok_end;
      logic              truncated;
      logic              last;
   } token_beat_type;

   // one directed source beat, with a typed expectation where it is obvious
   typedef struct packed {
      logic [7:0]        ch;
      logic              eoi;
      logic              typed;
      knt_pkg::kind_type kind;
      logic [7:0]        text;
      logic              has;
   } script_row_type;

   localparam logic [7:0] SYMBOLS [7] = '{knt_pkg::CH_PLUS, knt_pkg::CH_MINUS,
                                         knt_pkg::CH_STAR, knt_pkg::CH_LBRACE,
                                         knt_pkg::CH_RBRACE, knt_pkg::CH_EQ,
                                         knt_pkg::CH_SEMI};

   // single tokens and extremes, then if, else, a comment closed by cr, a number, int,
   // and a word flushed by the end marker
   localparam script_row_type SCRIPT [27] = '{
      '{knt_pkg::CH_PLUS,   1'b0, 1'b1, knt_pkg::KIND_PLUS,    8'h00, 1'b0},
      '{knt_pkg::CH_MINUS,  1'b0, 1'b1, knt_pkg::KIND_MINUS,   8'h00, 1'b0},
      '{knt_pkg::CH_STAR,   1'b0, 1'b1, knt_pkg::KIND_MUL,     8'h00, 1'b0},
      '{knt_pkg::CH_LBRACE, 1'b0, 1'b1, knt_pkg::KIND_LBRACE,  8'h00, 1'b0},
      '{knt_pkg::CH_RBRACE, 1'b0, 1'b1, knt_pkg::KIND_RBRACE,  8'h00, 1'b0},
      '{knt_pkg::CH_EQ,     1'b0, 1'b1, knt_pkg::KIND_EQ,      8'h00, 1'b0},
      '{knt_pkg::CH_SEMI,   1'b0, 1'b1, knt_pkg::KIND_SEMI,    8'h00, 1'b0},
      '{8'h00,              1'b0, 1'b1, knt_pkg::KIND_UNKNOWN, 8'h00, 1'b1},
      '{8'hFF,              1'b0, 1'b1, knt_pkg::KIND_UNKNOWN, 8'hFF, 1'b1},
      '{8'hA5,              1'b1, 1'b1, knt_pkg::KIND_EOF,     8'h00, 1'b0},
      '{"i",                1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{"f",                1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{knt_pkg::CH_LF,     1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{"e",                1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{"l",                1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{"s",                1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{"e",                1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{knt_pkg::CH_HASH,   1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{knt_pkg::CH_CR,     1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{"4",                1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{"2",                1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{"i",                1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{"n",                1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{"t",                1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{knt_pkg::CH_SPACE,  1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{knt_pkg::CH_UNDER,  1'b0, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0},
      '{8'h3C,              1'b1, 1'b0, knt_pkg::KIND_IDENT,   8'h00, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   knt_req_if req_chan ();
   knt_rsp_if rsp_chan ();

   keyword_number_tokenizer_unit #(.MAX_WORD(MAX_WORD)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   // lexer model state
   knt_pkg::mode_type lex_mode;
   logic [7:0]        word_chars [MAX_WORD];
   int                word_len;
   bit                word_overflow;
   token_beat_type    step_beats [$];
   token_beat_type    pending_tokens [$];

   int chars_sent;
   int beats_seen;
   int mismatch_count;
   bit idle_on;

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_numeral(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_word_char(input logic [7:0] c);
      return is_alpha(c) || is_numeral(c) || c == knt_pkg::CH_UNDER;
   endfunction

   function automatic void add_beat(input knt_pkg::kind_type k, input logic [7:0] t,
                                    input int p, input logic h, input logic e,
                                    input logic tr);
      token_beat_type b;
      b.kind      = k;
      b.text      = t;
      b.pos       = 5'(p);
      b.has_text  = h;
      b.tok_end   = e;
      b.truncated = tr;
      b.last      = 1'b0;
      step_beats  = {step_beats, b};
   endfunction

   function automatic void append_char(input logic [7:0] c);
      if (word_len < MAX_WORD) begin
         word_chars[word_len] = c;
         word_len++;
      end else begin
         word_overflow = 1'b1;
      end
   endfunction

   function automatic bit word_equals(input string kw);
      if (word_overflow || word_len != kw.len()) return 1'b0;
      for (int k = 0; k < word_len; k++) begin
         if (word_chars[k] != kw[k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // emit the buffered word or number, keywords as one beat
   function automatic void flush_word();
      knt_pkg::kind_type k;
      k = (lex_mode == knt_pkg::MODE_NUMBER) ? knt_pkg::KIND_NUMBER : knt_pkg::KIND_IDENT;
      if (k == knt_pkg::KIND_IDENT && word_equals("if")) begin
         add_beat(knt_pkg::KIND_IF, 8'h00, 0, 1'b0, 1'b1, 1'b0);
      end else if (k == knt_pkg::KIND_IDENT && word_equals("else")) begin
         add_beat(knt_pkg::KIND_ELSE, 8'h00, 0, 1'b0, 1'b1, 1'b0);
      end else if (k == knt_pkg::KIND_IDENT && word_equals("int")) begin
         add_beat(knt_pkg::KIND_INT, 8'h00, 0, 1'b0, 1'b1, 1'b0);
      end else begin
         for (int n = 0; n < word_len; n++)
            add_beat(k, word_chars[n], n, 1'b1, n + 1 == word_len, word_overflow);
      end
   endfunction

   // character seen between tokens
   function automatic void begin_token(input logic [7:0] c);
      lex_mode = knt_pkg::MODE_START;
      if (c == knt_pkg::CH_SPACE || c == knt_pkg::CH_LF) begin
         return;
      end else if (is_word_char(c)) begin
         lex_mode      = is_numeral(c) ? knt_pkg::MODE_NUMBER : knt_pkg::MODE_WORD;
         word_len      = 0;
         word_overflow = 1'b0;
         append_char(c);
      end else if (c == knt_pkg::CH_HASH) begin
         lex_mode = knt_pkg::MODE_COMMENT;
      end else begin
         case (c)
            knt_pkg::CH_PLUS:   add_beat(knt_pkg::KIND_PLUS,   8'h00, 0, 1'b0, 1'b1, 1'b0);
            knt_pkg::CH_MINUS:  add_beat(knt_pkg::KIND_MINUS,  8'h00, 0, 1'b0, 1'b1, 1'b0);
            knt_pkg::CH_STAR:   add_beat(knt_pkg::KIND_MUL,    8'h00, 0, 1'b0, 1'b1, 1'b0);
            knt_pkg::CH_LBRACE: add_beat(knt_pkg::KIND_LBRACE, 8'h00, 0, 1'b0, 1'b1, 1'b0);
            knt_pkg::CH_RBRACE: add_beat(knt_pkg::KIND_RBRACE, 8'h00, 0, 1'b0, 1'b1, 1'b0);
            knt_pkg::CH_EQ:     add_beat(knt_pkg::KIND_EQ,     8'h00, 0, 1'b0, 1'b1, 1'b0);
            knt_pkg::CH_SEMI:   add_beat(knt_pkg::KIND_SEMI,   8'h00, 0, 1'b0, 1'b1, 1'b0);
            default:            add_beat(knt_pkg::KIND_UNKNOWN, c,    0, 1'b1, 1'b1, 1'b0);
         endcase
      end
   endfunction

   // advance the lexer model by one source beat, queue its tokens if asked
   function automatic void lex_byte(input logic [7:0] c, input logic eoi, input bit keep);
      step_beats.delete();
      if (eoi) begin
         if (lex_mode == knt_pkg::MODE_WORD || lex_mode == knt_pkg::MODE_NUMBER) flush_word();
         add_beat(knt_pkg::KIND_EOF, 8'h00, 0, 1'b0, 1'b1, 1'b0);
         lex_mode = knt_pkg::MODE_START;
      end else begin
         case (lex_mode)
            knt_pkg::MODE_WORD: begin
               if (is_word_char(c)) begin
                  append_char(c);
               end else begin
                  flush_word();
                  begin_token(c);
               end
            end
            knt_pkg::MODE_NUMBER: begin
               if (is_numeral(c)) begin
                  append_char(c);
               end else begin
                  flush_word();
                  begin_token(c);
               end
            end
            knt_pkg::MODE_COMMENT: begin
               if (c == knt_pkg::CH_LF || c == knt_pkg::CH_CR) begin_token(c);
            end
            default: begin_token(c);
         endcase
      end
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
      if (keep) pending_tokens = {pending_tokens, step_beats};
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t beat %0d %s: got 0x%0h expected 0x%0h", $realtime, beats_seen, what,
                  got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // compare one accepted token beat with the oldest expectation
   task automatic check_token();
      token_beat_type want;
      if (pending_tokens.size() == 0) begin
         report_mismatch("unexpected beat, kind", int'(rsp_chan.token_kind), 0);
      end else begin
         want = pending_tokens.pop_front();
         check_field("token_kind",     int'(rsp_chan.token_kind),     int'(want.kind));
         check_field("text_char",      int'(rsp_chan.text_char),      int'(want.text));
         check_field("char_index",     int'(rsp_chan.char_index),     int'(want.pos));
         check_field("has_text",       int'(rsp_chan.has_text),       int'(want.has_text));
         check_field("token_end",      int'(rsp_chan.token_end),      int'(want.tok_end));
         check_field("word_truncated", int'(rsp_chan.word_truncated), int'(want.truncated));
         check_field("last",           int'(rsp_chan.last),           int'(want.last));
      end
      beats_seen++;
   endtask

   // drive one source beat, wait for it to be taken, then maybe idle a burst
   task automatic send_char(input logic [7:0] c, input logic eoi, input bit typed,
                            input token_beat_type typed_beat);
      int gap;
      req_chan.valid        <= 1'b1;
      req_chan.char_byte    <= c;
      req_chan.end_of_input <= eoi;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      lex_byte(c, eoi, !typed);
      if (typed) pending_tokens = {pending_tokens, typed_beat};
      chars_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_plain(input logic [7:0] c, input logic eoi);
      send_char(c, eoi, 1'b0, '0);
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_word_char(input bit lead);
      int r;
      r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
      if (r < 26) return LOW_A + 8'(r);
      if (r < 52) return UP_A + 8'(r - 26);
      if (r == 52) return knt_pkg::CH_UNDER;
      return DIGIT_0 + 8'(r - 53);
   endfunction

   function automatic logic [7:0] pick_digit();
      return DIGIT_0 + 8'($urandom_range(0, 9));
   endfunction

   // something after a word: blank, symbol, end marker, comment start, cr or any byte, which may also extend it
   task automatic send_separator();
      case ($urandom_range(0, 7))
         0, 1:    send_plain(knt_pkg::CH_SPACE, 1'b0);
         2:       send_plain(knt_pkg::CH_LF, 1'b0);
         3:       send_plain(SYMBOLS[$urandom_range(0, 6)], 1'b0);
         4:       send_plain(8'($urandom), 1'b1);
         5:       send_plain(knt_pkg::CH_HASH, 1'b0);
         6:       send_plain(knt_pkg::CH_CR, 1'b0);
         default: send_plain(8'($urandom), 1'b0);
      endcase
   endtask

   // one random fragment of source text
   task automatic send_fragment(input int seq_no);
      int         len;
      string      kw;
      logic [7:0] c;
      if (seq_no % 25 == 7) begin
         // long word or number around the buffer size
         len = $urandom_range(30, 40);
         if ($urandom_range(0, 1)) begin
            send_plain(pick_word_char(1'b1), 1'b0);
            repeat (len - 1) send_plain(pick_word_char(1'b0), 1'b0);
         end else begin
            repeat (len) send_plain(pick_digit(), 1'b0);
         end
         send_separator();
      end else begin
         case ($urandom_range(0, 15))
            0, 1, 2, 3: begin
               len = $urandom_range(1, 6);
               send_plain(pick_word_char(1'b1), 1'b0);
               repeat (len - 1) send_plain(pick_word_char(1'b0), 1'b0);
               if ($urandom_range(0, 3) != 0) send_separator();
            end
            4, 5, 6: begin
               case ($urandom_range(0, 2))
                  0:       kw = "if";
                  1:       kw = "else";
                  default: kw = "int";
               endcase
               for (int k = 0; k < kw.len(); k++) send_plain(kw[k], 1'b0);
               // now and then spoil the keyword
               if ($urandom_range(0, 3) == 0) send_plain(pick_word_char(1'b0), 1'b0);
               send_separator();
            end
            7, 8: begin
               len = $urandom_range(1, 5);
               repeat (len) send_plain(pick_digit(), 1'b0);
               if ($urandom_range(0, 3) != 0) send_separator();
            end
            9, 10: send_plain(SYMBOLS[$urandom_range(0, 6)], 1'b0);
            11: send_plain($urandom_range(0, 1) ? knt_pkg::CH_SPACE : knt_pkg::CH_LF, 1'b0);
            12: begin
               // comment with arbitrary body, closed by lf, cr or the end marker
               send_plain(knt_pkg::CH_HASH, 1'b0);
               len = $urandom_range(0, 6);
               repeat (len) begin
                  c = 8'($urandom);
                  if (c == knt_pkg::CH_LF || c == knt_pkg::CH_CR) c = knt_pkg::CH_SPACE;
                  send_plain(c, 1'b0);
               end
               case ($urandom_range(0, 2))
                  0:       send_plain(knt_pkg::CH_LF, 1'b0);
                  1:       send_plain(knt_pkg::CH_CR, 1'b0);
                  default: send_plain(8'($urandom), 1'b1);
               endcase
            end
            13, 14: send_plain(8'($urandom), $urandom_range(0, 15) == 0);
            default: send_plain(8'($urandom), 1'b1);
         endcase
      end
   endtask

   // token sink with random stall bursts
   initial begin : token_sink
      int stall;
      stall          = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) check_token();
         if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(0, 4);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no beat on either side
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("keyword_number_tokenizer_unit: mismatch");
      $finish;
   end

   // reset, directed script, random text, drain
   initial begin : stimulus
      script_row_type row;
      token_beat_type typed_beat;
      int             seq_no;
      int             total;
      bit             mid_pause_done;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.char_byte    = 8'h00;
      req_chan.end_of_input = 1'b0;
      lex_mode              = knt_pkg::MODE_START;
      word_len              = 0;
      word_overflow         = 1'b0;
      chars_sent            = 0;
      beats_seen            = 0;
      mismatch_count        = 0;
      idle_on               = 1'b1;
      seq_no                = 0;
      mid_pause_done        = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed script
      foreach (SCRIPT[r]) begin
         row                  = SCRIPT[r];
         typed_beat.kind      = row.kind;
         typed_beat.text      = row.text;
         typed_beat.pos       = 5'd0;
         typed_beat.has_text  = row.has;
         typed_beat.tok_end   = 1'b1;
         typed_beat.truncated = 1'b0;
         typed_beat.last      = 1'b1;
         send_char(row.ch, row.eoi, row.typed, typed_beat);
      end
      wait_for_drain();

      // random text, with a full drain halfway and no idling near the end
      total = chars_sent + RANDOM_CHARS;
      while (chars_sent < total) begin
         if (chars_sent >= total - CALM_CHARS) idle_on = 1'b0;
         if (!mid_pause_done && chars_sent >= total - RANDOM_CHARS / 2) begin
            wait_for_drain();
            mid_pause_done = 1'b1;
         end
         send_fragment(seq_no);
         seq_no++;
      end
      req_chan.valid <= 1'b0;

      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("keyword_number_tokenizer_unit: match");
      else
         $display("keyword_number_tokenizer_unit: mismatch");
      $finish;
   end

endmodule
